@@ hw/rtl/c3zp_pkg.sv @@
// ----------------------------------------------------------------------------
// c3zp_pkg
// Shared types and constants of the 3x3 zero padded convolution stream core.
// ----------------------------------------------------------------------------
`default_nettype none

package c3zp_pkg;

  localparam int unsigned KSIZE    = 3;
  localparam int unsigned NCOEF    = KSIZE * KSIZE;
  localparam int unsigned PIX_W    = 16;
  localparam int unsigned PROD_W   = 2 * PIX_W;
  localparam int unsigned RSUM_W   = PROD_W + 2;
  localparam int unsigned OUT_W    = 36;
  localparam int unsigned DIM_W    = 13;
  localparam int unsigned MAX_ROWS = 4096;

  localparam logic [DIM_W-1:0] ROW_MAX = 13'd8191;

  localparam int unsigned ADDR_W = 6;
  localparam int unsigned DATA_W = 64;

  localparam logic [10:0] WIDTH_RST = 11'd1024;
  localparam logic [12:0] HEIGHT_RST = 13'd1024;
  localparam logic [47:0] KTOP_RST = 48'h0000_0000_0000;
  localparam logic [47:0] KMID_RST = 48'h0000_4000_0000;
  localparam logic [47:0] KBOT_RST = 48'h0000_0000_0000;

  typedef enum logic [2:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_KTOP   = 3'd2,
    REG_KMID   = 3'd3,
    REG_KBOT   = 3'd4
  } c3zp_reg_e;

  typedef struct packed {
    logic signed [15:0] pixel_value;
    logic               drain;
  } c3zp_in_t;

  typedef struct packed {
    logic signed [35:0] filtered_value;
    logic               frame_last;
  } c3zp_out_t;

  typedef struct packed {
    logic [12:0] width;
    logic [12:0] height;
  } c3zp_geom_t;

  typedef logic [8:0][15:0] c3zp_kern_t;

endpackage

`default_nettype wire

@@ hw/rtl/conv3x3_zero_padded_stream_core.sv @@
// ----------------------------------------------------------------------------
// conv3x3_zero_padded_stream_core
// A result passes the line RAM read, window, products, row sums and output
// registers after the pixel transfer that completes its window. Throughput:
// one input transfer per cycle unless the output stalls, set by the single
// line RAM port pair and nine parallel multipliers. Reset restores register
// defaults and clears counters and pipeline; line RAM contents are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module conv3x3_zero_padded_stream_core #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire c3zp_pkg::c3zp_in_t          in_data_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output c3zp_pkg::c3zp_out_t              out_data_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [c3zp_pkg::ADDR_W-1:0] paddr,
  input  wire logic [c3zp_pkg::DATA_W-1:0] pwdata,
  output logic      [c3zp_pkg::DATA_W-1:0] prdata,
  output logic                             pready
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned OW = $clog2(MAX_WIDTH * c3zp_pkg::MAX_ROWS + 1);
  localparam int unsigned RW = c3zp_pkg::DIM_W;
  localparam int unsigned PW = c3zp_pkg::PIX_W;
  localparam int unsigned KS = c3zp_pkg::KSIZE;

  function automatic logic [RW-1:0] row_inc(input logic [RW-1:0] r);
    return (r == c3zp_pkg::ROW_MAX) ? r : r + RW'(1);
  endfunction

  c3zp_pkg::c3zp_geom_t geom;
  c3zp_pkg::c3zp_kern_t kern;
  logic [OW-1:0]        total;
  logic [WW-1:0]        w;
  logic [RW-1:0]        h;

  c3zp_cfg #(.MAX_WIDTH(MAX_WIDTH)) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .geom_o  (geom),
    .kern_o  (kern),
    .total_o (total)
  );

  assign w = geom.width[WW-1:0];
  assign h = geom.height;

  // Position state
  logic [CW-1:0] col_q;
  logic [RW-1:0] row_q;
  logic [OW-1:0] cnt_q;

  // Input decode
  logic          restart, row_done, active, eff_drain, wrap1, wrap2, emit, last;
  logic [CW-1:0] col0, c, col_d, ox;
  logic [RW-1:0] row0, r1, row_d, oy;
  logic [OW-1:0] cnt0, cnt_d;
  logic [WW-1:0] c_inc;
  logic signed [PW-1:0] pix;
  logic [KS-1:0] rm, cm;
  logic          in_fire;

  // Pipeline control
  logic s1_v_q, s2_v_q, p_v_q, rs_v_q, out_v_q;
  logic s1_adv, s2_move, p_move, rs_move;
  logic s2_free, p_free, rs_free, out_free;

  // Stage 1 payload
  logic [CW-1:0]        s1_c_q;
  logic signed [PW-1:0] s1_pix_q;
  logic                 s1_emit_q, s1_last_q;
  logic [KS-1:0]        s1_rm_q, s1_cm_q;
  logic                 byp_q;
  logic signed [PW-1:0] byp_prev_q, byp_older_q;
  logic [2*PW-1:0]      ram_rdata;
  logic signed [PW-1:0] prev_eff, older_eff;

  // Window and later stages
  logic signed [PW-1:0] win_q [KS][KS];
  logic [KS-1:0]        s2_rm_q, s2_cm_q;
  logic                 s2_last_q, p_last_q, rs_last_q, out_last_q;
  logic signed [c3zp_pkg::PROD_W-1:0] prod_d [KS][KS];
  logic signed [c3zp_pkg::PROD_W-1:0] prod_q [KS][KS];
  logic signed [c3zp_pkg::RSUM_W-1:0] rs_d [KS];
  logic signed [c3zp_pkg::RSUM_W-1:0] rs_q [KS];
  logic signed [c3zp_pkg::OUT_W-1:0]  out_d;
  logic signed [c3zp_pkg::OUT_W-1:0]  out_q;

  always_comb begin
    restart   = cnt_q >= total;
    col0      = restart ? '0 : col_q;
    row0      = restart ? '0 : row_q;
    cnt0      = restart ? '0 : cnt_q;
    row_done  = row0 >= h;
    active    = !(in_data_i.drain && !row_done);
    eff_drain = in_data_i.drain || row_done;
    wrap1     = WW'(col0) >= w;
    c         = wrap1 ? '0 : col0;
    r1        = wrap1 ? row_inc(row0) : row0;
    c_inc     = WW'(c) + WW'(1);
    wrap2     = c_inc >= w;
    col_d     = wrap2 ? '0 : c_inc[CW-1:0];
    row_d     = wrap2 ? row_inc(r1) : r1;
    emit      = ((r1 >= RW'(2)) || (r1 == RW'(1) && c != '0)) && (cnt0 < total);
    cnt_d     = emit ? cnt0 + OW'(1) : cnt0;
    last      = cnt0 == total - OW'(1);
    pix       = eff_drain ? '0 : in_data_i.pixel_value;
    if (c != '0) begin
      ox = c - CW'(1);
      oy = r1 - RW'(1);
    end else begin
      ox = CW'(w - WW'(1));
      oy = r1 - RW'(2);
    end
    cm[0] = ox != '0;
    cm[1] = 1'b1;
    cm[2] = (WW'(ox) + WW'(1)) < w;
    rm[0] = (oy != '0) && (oy <= h);
    rm[1] = oy < h;
    rm[2] = ({1'b0, oy} + (RW+1)'(1)) < {1'b0, h};
  end

  // Ready chain, each stage moves when the next one is empty or moving
  assign out_free = !out_v_q || out_ready_i;
  assign rs_move  = rs_v_q && out_free;
  assign rs_free  = !rs_v_q || out_free;
  assign p_move   = p_v_q && rs_free;
  assign p_free   = !p_v_q || rs_free;
  assign s2_move  = s2_v_q && p_free;
  assign s2_free  = !s2_v_q || p_free;
  assign s1_adv   = s1_v_q && s2_free;
  assign in_ready_o = !s1_v_q || s2_free;
  assign in_fire  = in_valid_i && in_ready_o;

  // Line RAM: upper half older row, lower half previous row
  c3zp_ram #(.WIDTH(2 * PW), .DEPTH(MAX_WIDTH)) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_c_q),
    .wdata_i ({prev_eff, s1_pix_q}),
    .re_i    (in_fire && active),
    .raddr_i (c),
    .rdata_o (ram_rdata)
  );

  // Write and read of one column in the same cycle: forward the written data
  assign prev_eff  = byp_q ? byp_prev_q  : ram_rdata[PW-1:0];
  assign older_eff = byp_q ? byp_older_q : ram_rdata[2*PW-1:PW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      cnt_q   <= '0;
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      p_v_q   <= 1'b0;
      rs_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      for (int i = 0; i < KS; i++) begin
        for (int j = 0; j < KS; j++) begin
          win_q[i][j] <= '0;
        end
      end
    end else begin
      if (in_fire && active) begin
        col_q <= col_d;
        row_q <= row_d;
        cnt_q <= cnt_d;
      end
      if (in_fire) begin
        s1_v_q <= active;
      end else if (s1_adv) begin
        s1_v_q <= 1'b0;
      end
      if (s1_adv) begin
        s2_v_q <= s1_emit_q;
        for (int i = 0; i < KS; i++) begin
          for (int j = 0; j < KS - 1; j++) begin
            win_q[i][j] <= win_q[i][j+1];
          end
        end
        win_q[0][KS-1] <= older_eff;
        win_q[1][KS-1] <= prev_eff;
        win_q[2][KS-1] <= s1_pix_q;
      end else if (s2_move) begin
        s2_v_q <= 1'b0;
      end
      if (s2_move) begin
        p_v_q <= 1'b1;
      end else if (p_move) begin
        p_v_q <= 1'b0;
      end
      if (p_move) begin
        rs_v_q <= 1'b1;
      end else if (rs_move) begin
        rs_v_q <= 1'b0;
      end
      if (rs_move) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < KS; i++) begin
      for (int j = 0; j < KS; j++) begin
        prod_d[i][j] = (s2_rm_q[i] && s2_cm_q[j])
                       ? c3zp_pkg::PROD_W'(win_q[i][j])
                         * c3zp_pkg::PROD_W'($signed(kern[(KS-1-j) + (KS-1-i) * KS]))
                       : '0;
      end
    end
    for (int i = 0; i < KS; i++) begin
      rs_d[i] = c3zp_pkg::RSUM_W'(prod_q[i][0]) + c3zp_pkg::RSUM_W'(prod_q[i][1])
                + c3zp_pkg::RSUM_W'(prod_q[i][2]);
    end
    out_d = c3zp_pkg::OUT_W'(rs_q[0]) + c3zp_pkg::OUT_W'(rs_q[1])
            + c3zp_pkg::OUT_W'(rs_q[2]);
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && active) begin
      s1_c_q      <= c;
      s1_pix_q    <= pix;
      s1_emit_q   <= emit;
      s1_last_q   <= last;
      s1_rm_q     <= rm;
      s1_cm_q     <= cm;
      byp_q       <= s1_adv && (s1_c_q == c);
      byp_prev_q  <= s1_pix_q;
      byp_older_q <= prev_eff;
    end
    if (s1_adv) begin
      s2_rm_q   <= s1_rm_q;
      s2_cm_q   <= s1_cm_q;
      s2_last_q <= s1_last_q;
    end
    if (s2_move) begin
      prod_q   <= prod_d;
      p_last_q <= s2_last_q;
    end
    if (p_move) begin
      rs_q      <= rs_d;
      rs_last_q <= p_last_q;
    end
    if (rs_move) begin
      out_q      <= out_d;
      out_last_q <= rs_last_q;
    end
  end

  assign out_valid_o               = out_v_q;
  assign out_data_o.filtered_value = out_q;
  assign out_data_o.frame_last     = out_last_q;

endmodule

`default_nettype wire

@@ hw/rtl/c3zp_ram.sv @@
// ----------------------------------------------------------------------------
// c3zp_ram
// Simple dual port RAM, one write and one registered read port, read first.
// ----------------------------------------------------------------------------
`default_nettype none

module c3zp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ hw/rtl/c3zp_cfg.sv @@
// ----------------------------------------------------------------------------
// c3zp_cfg
// APB register file: frame geometry, kernel rows and the pixel total of a frame.
// ----------------------------------------------------------------------------
`default_nettype none

module c3zp_cfg #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      rst_ni,
  input  wire logic                                      psel,
  input  wire logic                                      penable,
  input  wire logic                                      pwrite,
  input  wire logic [c3zp_pkg::ADDR_W-1:0]               paddr,
  input  wire logic [c3zp_pkg::DATA_W-1:0]               pwdata,
  output logic      [c3zp_pkg::DATA_W-1:0]               prdata,
  output logic                                           pready,
  output c3zp_pkg::c3zp_geom_t                           geom_o,
  output c3zp_pkg::c3zp_kern_t                           kern_o,
  output logic [$clog2(MAX_WIDTH*c3zp_pkg::MAX_ROWS+1)-1:0] total_o
);

  localparam int unsigned OW = $clog2(MAX_WIDTH * c3zp_pkg::MAX_ROWS + 1);
  localparam int unsigned MW = 2 * c3zp_pkg::DIM_W;
  localparam logic [c3zp_pkg::DIM_W-1:0] WMax = c3zp_pkg::DIM_W'(MAX_WIDTH);
  localparam logic [c3zp_pkg::DIM_W-1:0] HMax = c3zp_pkg::DIM_W'(c3zp_pkg::MAX_ROWS);
  localparam int unsigned RstW = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
  localparam logic [OW-1:0] TotalRst = OW'(RstW * 1024);

  function automatic logic [c3zp_pkg::DIM_W-1:0] clamp_dim(
    input logic [c3zp_pkg::DIM_W-1:0] v,
    input logic [c3zp_pkg::DIM_W-1:0] hi
  );
    logic [c3zp_pkg::DIM_W-1:0] r;
    if (v == '0) begin
      r = c3zp_pkg::DIM_W'(1);
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  logic [10:0] width_q;
  logic [12:0] height_q;
  logic [47:0] ktop_q;
  logic [47:0] kmid_q;
  logic [47:0] kbot_q;
  logic [OW-1:0] total_q;
  logic [OW-1:0] total_d;

  c3zp_pkg::c3zp_reg_e idx;
  logic wr_en;
  logic [c3zp_pkg::DIM_W-1:0] w_cur;
  logic [c3zp_pkg::DIM_W-1:0] h_cur;
  logic [c3zp_pkg::DIM_W-1:0] w_mul;
  logic [c3zp_pkg::DIM_W-1:0] h_mul;
  logic [MW-1:0] prod;

  assign idx    = c3zp_pkg::c3zp_reg_e'(paddr[5:3]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    w_cur = clamp_dim(c3zp_pkg::DIM_W'(width_q), WMax);
    h_cur = clamp_dim(height_q, HMax);
    w_mul = (wr_en && idx == c3zp_pkg::REG_WIDTH)
            ? clamp_dim(c3zp_pkg::DIM_W'(pwdata[10:0]), WMax) : w_cur;
    h_mul = (wr_en && idx == c3zp_pkg::REG_HEIGHT)
            ? clamp_dim(pwdata[12:0], HMax) : h_cur;
    prod    = MW'(w_mul) * MW'(h_mul);
    total_d = prod[OW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= c3zp_pkg::WIDTH_RST;
      height_q <= c3zp_pkg::HEIGHT_RST;
      ktop_q   <= c3zp_pkg::KTOP_RST;
      kmid_q   <= c3zp_pkg::KMID_RST;
      kbot_q   <= c3zp_pkg::KBOT_RST;
      total_q  <= TotalRst;
    end else begin
      if (wr_en) begin
        unique case (idx)
          c3zp_pkg::REG_WIDTH:  width_q  <= pwdata[10:0];
          c3zp_pkg::REG_HEIGHT: height_q <= pwdata[12:0];
          c3zp_pkg::REG_KTOP:   ktop_q   <= pwdata[47:0];
          c3zp_pkg::REG_KMID:   kmid_q   <= pwdata[47:0];
          c3zp_pkg::REG_KBOT:   kbot_q   <= pwdata[47:0];
          default: begin
          end
        endcase
      end
      total_q <= total_d;
    end
  end

  always_comb begin
    unique case (idx)
      c3zp_pkg::REG_WIDTH:  prdata = c3zp_pkg::DATA_W'(width_q);
      c3zp_pkg::REG_HEIGHT: prdata = c3zp_pkg::DATA_W'(height_q);
      c3zp_pkg::REG_KTOP:   prdata = c3zp_pkg::DATA_W'(ktop_q);
      c3zp_pkg::REG_KMID:   prdata = c3zp_pkg::DATA_W'(kmid_q);
      c3zp_pkg::REG_KBOT:   prdata = c3zp_pkg::DATA_W'(kbot_q);
      default:              prdata = '0;
    endcase
  end

  assign geom_o.width  = w_cur;
  assign geom_o.height = h_cur;
  assign kern_o        = {kbot_q, kmid_q, ktop_q};
  assign total_o       = total_q;

endmodule

`default_nettype wire

@@ tb/sv/conv3x3_zero_padded_stream_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// conv3x3_zero_padded_stream_core_tb
// Self-checking bench for the 3x3 zero padded convolution stream core.
// A short table of directed transfers opens the run. Randomly sized frames
// follow under changing geometry, kernels and flow control. Every result is
// compared field by field against the table or an in-bench model of the
// window and line stores. Registers are written over APB only while the core
// is idle, and each write is read back.
// ----------------------------------------------------------------------------

module conv3x3_zero_padded_stream_core_tb;
  import c3zp_pkg::*;

  localparam int unsigned LINE_MAX      = 1024;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned RAND_ITEMS    = 720;
  localparam int unsigned EDGE_ITEMS    = 40;
  localparam int unsigned DIR_ROWS      = 17;

  typedef enum logic [1:0] {
    FLOW_FREE,
    FLOW_SRC_GAPS,
    FLOW_SINK_STALLS,
    FLOW_BOTH
  } flow_mode_e;

  typedef struct packed {
    c3zp_in_t  item;
    logic      typed;
    c3zp_out_t want;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  c3zp_in_t            in_data;
  logic                out_valid;
  logic                out_ready;
  c3zp_out_t           out_data;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  flow_mode_e          flow;
  c3zp_out_t           sums_pending [$];
  c3zp_out_t           sum_want;
  dir_row_t            dir_tab [DIR_ROWS];
  int unsigned         err_count;
  int unsigned         xfers_in;
  int unsigned         results_seen;
  int unsigned         frames_seen;
  int unsigned         reg_writes;
  int unsigned         rand_items;

  // model state
  logic [10:0]         cfg_width;
  logic [12:0]         cfg_height;
  logic [47:0]         kern_rows [3];
  logic signed [15:0]  prev_px [LINE_MAX];
  logic signed [15:0]  older_px [LINE_MAX];
  logic signed [15:0]  win [3][3];
  int unsigned         pix_col;
  int unsigned         pix_row;
  int unsigned         sums_out;

  conv3x3_zero_padded_stream_core #(
    .MAX_WIDTH(LINE_MAX)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #10 clk = ~clk;

  function automatic int unsigned geom_w();
    int unsigned w;
    w = cfg_width;
    if (w < 1) w = 1;
    if (w > LINE_MAX) w = LINE_MAX;
    return w;
  endfunction

  function automatic int unsigned geom_h();
    int unsigned h;
    h = cfg_height;
    if (h < 1) h = 1;
    if (h > MAX_ROWS) h = MAX_ROWS;
    return h;
  endfunction

  function automatic bit frame_done();
    return sums_out >= geom_w() * geom_h();
  endfunction

  function automatic logic signed [15:0] coef_at(int idx);
    logic [47:0] kr;
    kr = kern_rows[idx / 3];
    return kr[(idx % 3) * 16 +: 16];
  endfunction

  function automatic logic signed [15:0] rand_pixel();
    case ($urandom_range(7))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return 16'sd0;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_coef();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h4000;
      3: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [63:0] reg_mask(c3zp_reg_e idx);
    case (idx)
      REG_WIDTH:  return 64'h7FF;
      REG_HEIGHT: return 64'h1FFF;
      default:    return 64'hFFFF_FFFF_FFFF;
    endcase
  endfunction

  function automatic bit src_gap();
    return (flow == FLOW_SRC_GAPS && $urandom_range(99) < 47) ||
           (flow == FLOW_BOTH && $urandom_range(99) < 19);
  endfunction

  function automatic bit sink_stall();
    return (flow == FLOW_SINK_STALLS && $urandom_range(99) < 47) ||
           (flow == FLOW_BOTH && $urandom_range(99) < 19);
  endfunction

  function automatic dir_row_t mk_row(logic signed [15:0] px, logic dr, logic typed,
                                      logic signed [35:0] val, logic last);
    dir_row_t rw;
    rw.item.pixel_value   = px;
    rw.item.drain         = dr;
    rw.typed              = typed;
    rw.want.filtered_value = val;
    rw.want.frame_last     = last;
    return rw;
  endfunction

  task automatic conv_step(input c3zp_in_t it, output bit got, output c3zp_out_t res);
    int unsigned w, h, total, c, r;
    bit flush;
    logic signed [15:0] px;
    longint acc;
    int ox, oy, wr, wc;
    got = 1'b0;
    res = '0;
    w = geom_w();
    h = geom_h();
    total = w * h;
    flush = it.drain;
    if (sums_out >= total) begin
      if (flush) return;
      pix_col  = 0;
      pix_row  = 0;
      sums_out = 0;
    end
    if (!flush && pix_row >= h) flush = 1'b1;
    if (flush && pix_row < h) return;
    if (pix_col >= w) begin
      pix_col = 0;
      if (pix_row < ROW_MAX) pix_row++;
    end
    c = pix_col;
    r = pix_row;
    px = flush ? 16'sd0 : it.pixel_value;
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2]   = older_px[c];
    win[1][2]   = prev_px[c];
    win[2][2]   = px;
    older_px[c] = prev_px[c];
    prev_px[c]  = px;
    pix_col = c + 1;
    if (pix_col >= w) begin
      pix_col = 0;
      if (pix_row < ROW_MAX) pix_row++;
    end
    if ((r >= 2 || (r == 1 && c >= 1)) && sums_out < total) begin
      if (c >= 1) begin
        ox = int'(c) - 1;
        oy = int'(r) - 1;
      end else begin
        ox = int'(w) - 1;
        oy = int'(r) - 2;
      end
      acc = 0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          wr = oy - 1 + i;
          wc = ox - 1 + j;
          if (wr >= 0 && wr < int'(h) && wc >= 0 && wc < int'(w)) begin
            acc += longint'(coef_at((2 - j) + (2 - i) * 3)) * longint'(win[i][j]);
          end
        end
      end
      res.filtered_value = acc[35:0];
      res.frame_last     = (sums_out == total - 1);
      sums_out++;
      got = 1'b1;
    end
  endtask

  task automatic reg_access(input c3zp_reg_e idx, input bit wr, input logic [63:0] val);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = ADDR_W'(int'(idx) * 8);
    pwdata  = wr ? val : '0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (!wr && prdata !== val) begin
      $error("register %s readback exp %0h act %0h", idx.name(), val, prdata);
      err_count++;
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic reg_write(input c3zp_reg_e idx, input logic [63:0] val);
    logic [63:0] kept;
    kept = val & reg_mask(idx);
    reg_access(idx, 1'b1, val);
    case (idx)
      REG_WIDTH:  cfg_width  = kept[10:0];
      REG_HEIGHT: cfg_height = kept[12:0];
      REG_KTOP:   kern_rows[0] = kept[47:0];
      REG_KMID:   kern_rows[1] = kept[47:0];
      REG_KBOT:   kern_rows[2] = kept[47:0];
      default: ;
    endcase
    reg_writes++;
    reg_access(idx, 1'b0, kept);
  endtask

  task automatic set_kernels(input logic [47:0] top, input logic [47:0] mid,
                             input logic [47:0] bot);
    reg_write(REG_KTOP, 64'(top));
    reg_write(REG_KMID, 64'(mid));
    reg_write(REG_KBOT, 64'(bot));
  endtask

  // called right after a falling edge, valid low
  task automatic send_item(input c3zp_in_t it, input logic typed, input c3zp_out_t want);
    bit got;
    c3zp_out_t res;
    while (src_gap()) @(negedge clk);
    in_valid = 1'b1;
    in_data  = it;
    do @(posedge clk); while (!in_ready);
    xfers_in++;
    conv_step(it, got, res);
    if (typed && !got) begin
      $error("directed row expects a result the model does not produce");
      err_count++;
    end
    if (got) begin
      if (res.frame_last) frames_seen++;
      sums_pending.push_back(typed ? want : res);
    end
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic run_pixels(input int unsigned count);
    c3zp_in_t it;
    for (int n = 0; n < int'(count); n++) begin
      it.drain = 1'b0;
      it.pixel_value = rand_pixel();
      send_item(it, 1'b0, '0);
    end
  endtask

  task automatic run_frame(input bit counted);
    c3zp_in_t it;
    bit started;
    started = 1'b0;
    while (!started || !frame_done()) begin
      if (!frame_done() && pix_row < geom_h() && $urandom_range(19) == 0) begin
        it.drain = 1'b1;
        it.pixel_value = rand_pixel();
        send_item(it, 1'b0, '0);
      end
      if (frame_done() || pix_row < geom_h()) begin
        it.drain = 1'b0;
      end else begin
        it.drain = ($urandom_range(3) != 0);
      end
      it.pixel_value = rand_pixel();
      send_item(it, 1'b0, '0);
      if (counted) rand_items++;
      started = 1'b1;
    end
    if ($urandom_range(5) == 0) begin
      it.drain = 1'b1;
      it.pixel_value = rand_pixel();
      send_item(it, 1'b0, '0);
    end
  endtask

  task automatic settle();
    while (sums_pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_ready = !sink_stall();
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (sums_pending.size() == 0) begin
        $error("result with no pending expectation, filtered_value %0d",
               out_data.filtered_value);
        err_count++;
      end else begin
        sum_want = sums_pending.pop_front();
        results_seen++;
        if (out_data.filtered_value !== sum_want.filtered_value) begin
          $error("filtered_value exp %0d act %0d",
                 sum_want.filtered_value, out_data.filtered_value);
          err_count++;
        end
        if (out_data.frame_last !== sum_want.frame_last) begin
          $error("frame_last exp %0b act %0b", sum_want.frame_last, out_data.frame_last);
          err_count++;
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int unsigned phase;
    int unsigned frames;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    rst_n     = 1'b0;
    flow      = FLOW_FREE;
    err_count = 0;
    xfers_in  = 0;
    results_seen = 0;
    frames_seen  = 0;
    reg_writes   = 0;
    rand_items   = 0;
    cfg_width    = WIDTH_RST;
    cfg_height   = HEIGHT_RST;
    kern_rows[0] = KTOP_RST;
    kern_rows[1] = KMID_RST;
    kern_rows[2] = KBOT_RST;
    for (int i = 0; i < LINE_MAX; i++) begin
      prev_px[i]  = '0;
      older_px[i] = '0;
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) win[i][j] = '0;
    end
    pix_col  = 0;
    pix_row  = 0;
    sums_out = 0;

    // 2x2 frame, identity kernel: each result is its centre pixel times 16384 (1.0 in Q2.14)
    dir_tab[0]  = mk_row(16'sd0,      1'b1, 1'b0, 36'sd0, 1'b0);
    dir_tab[1]  = mk_row(16'sd32767,  1'b0, 1'b0, 36'sd0, 1'b0);
    dir_tab[2]  = mk_row(-16'sd32768, 1'b0, 1'b0, 36'sd0, 1'b0);
    dir_tab[3]  = mk_row(16'sd5,      1'b1, 1'b0, 36'sd0, 1'b0);
    dir_tab[4]  = mk_row(16'sd0,      1'b0, 1'b0, 36'sd0, 1'b0);
    dir_tab[5]  = mk_row(16'sd1,      1'b0, 1'b1, 36'sd536854528, 1'b0);
    dir_tab[6]  = mk_row(16'sd0,      1'b1, 1'b1, -36'sd536870912, 1'b0);
    dir_tab[7]  = mk_row(16'sd12345,  1'b0, 1'b1, 36'sd0, 1'b0);
    dir_tab[8]  = mk_row(16'sd0,      1'b1, 1'b1, 36'sd16384, 1'b1);
    dir_tab[9]  = mk_row(16'sd0,      1'b1, 1'b0, 36'sd0, 1'b0);
    dir_tab[10] = mk_row(16'sd100,    1'b0, 1'b0, 36'sd0, 1'b0);
    dir_tab[11] = mk_row(-16'sd200,   1'b0, 1'b0, 36'sd0, 1'b0);
    dir_tab[12] = mk_row(16'sd300,    1'b0, 1'b0, 36'sd0, 1'b0);
    dir_tab[13] = mk_row(-16'sd400,   1'b0, 1'b0, 36'sd0, 1'b0);
    dir_tab[14] = mk_row(16'sd0,      1'b1, 1'b0, 36'sd0, 1'b0);
    dir_tab[15] = mk_row(-16'sd1,     1'b0, 1'b0, 36'sd0, 1'b0);
    dir_tab[16] = mk_row(16'sd0,      1'b1, 1'b0, 36'sd0, 1'b0);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    reg_access(REG_WIDTH,  1'b0, 64'(WIDTH_RST));
    reg_access(REG_HEIGHT, 1'b0, 64'(HEIGHT_RST));
    reg_access(REG_KTOP,   1'b0, 64'(KTOP_RST));
    reg_access(REG_KMID,   1'b0, 64'(KMID_RST));
    reg_access(REG_KBOT,   1'b0, 64'(KBOT_RST));

    reg_write(REG_WIDTH, 64'd2);
    reg_write(REG_HEIGHT, 64'd2);
    set_kernels(48'h0, KMID_RST, 48'h0);
    for (int n = 0; n < DIR_ROWS; n++) begin
      send_item(dir_tab[n].item, dir_tab[n].typed, dir_tab[n].want);
    end
    settle();

    // single column, clamped tallest frame, largest positive coefficients, cut short
    flow = FLOW_BOTH;
    reg_write(REG_WIDTH, 64'd0);
    reg_write(REG_HEIGHT, 64'd8191);
    set_kernels(48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF);
    run_pixels(EDGE_ITEMS);
    settle();

    // height drops below the output count: next pixel opens a 1x1 frame
    flow = FLOW_SINK_STALLS;
    reg_write(REG_HEIGHT, 64'd0);
    set_kernels(48'h8000_8000_8000, 48'h8000_8000_8000, 48'h8000_8000_8000);
    run_frame(1'b0);
    settle();

    phase = 0;
    while (rand_items < RAND_ITEMS) begin
      flow = flow_mode_e'(phase % 4);
      if ($urandom_range(9) == 0) begin
        reg_write(REG_WIDTH, 64'($urandom_range(48, 9)));
      end else begin
        reg_write(REG_WIDTH, 64'($urandom_range(8, 1)));
      end
      reg_write(REG_HEIGHT, 64'($urandom_range(6, 1)));
      if ($urandom_range(1)) reg_write(REG_KTOP, 64'({rand_coef(), rand_coef(), rand_coef()}));
      if ($urandom_range(1)) reg_write(REG_KMID, 64'({rand_coef(), rand_coef(), rand_coef()}));
      if ($urandom_range(1)) reg_write(REG_KBOT, 64'({rand_coef(), rand_coef(), rand_coef()}));
      frames = $urandom_range(4, 1);
      repeat (frames) run_frame(1'b1);
      settle();
      phase++;
    end

    $display("Covered %0d input transfers, %0d frames, %0d register writes, %0d phases",
             xfers_in, frames_seen, reg_writes, phase + 3);
    $display("Compared %0d results, %0d mismatches", results_seen, err_count);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
